// ===== hw/rtl/bilinear_rgb565_gradient_pixel_top_defines.svh =====
// assertion helpers for the rtl files
`ifndef BILINEAR_RGB565_GRADIENT_PIXEL_TOP_DEFINES_SVH
`define BILINEAR_RGB565_GRADIENT_PIXEL_TOP_DEFINES_SVH

// antecedent implies consequent, consequent may open with a delay
`define BGP_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("bilinear gradient assertion failed");

// a finished divider leaves a remainder below its divisor
`define BGP_ASSERT_REM(label, clk, rst_n, vld, d) \
	`BGP_ASSERT(label, clk, rst_n, (vld) && (d.den != '0), (d.rem < 21'(d.den)))

`endif

// ===== hw/rtl/bgp_pkg.sv =====
package bgp_pkg;

	localparam int unsigned COORD_W = 12;
	localparam int unsigned DIM_W = 13;
	localparam int unsigned COLOUR_W = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned MAX_DIMENSION_DEF = 4096;

	localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_RIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_RIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LEFT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

	localparam int unsigned CH_RED = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE = 2;

	// one channel interpolation in flight through the restoring divider
	typedef struct packed {
		logic [20:0] rem;
		logic [13:0] den;
		logic [5:0]  quo;
		logic [5:0]  first;
		logic        neg;
	} div_t;

	function automatic logic [5:0] get_ch(logic [COLOUR_W-1:0] col, int unsigned ch);
		logic [5:0] v;
		unique case (ch)
			CH_RED:   v = {1'b0, col[15:11]};
			CH_GREEN: v = col[10:5];
			default:  v = {1'b0, col[4:0]};
		endcase
		return v;
	endfunction

	function automatic logic [COLOUR_W-1:0] pack565(logic [5:0] r, logic [5:0] g,
		logic [5:0] b);
		return {r[4:0], g[5:0], b[4:0]};
	endfunction

	// numerator 2*point*|diff| + steps over divisor 2*steps rounds half away from zero
	function automatic div_t mix_setup(logic [5:0] first, logic [5:0] last,
		logic [DIM_W-1:0] point, logic [DIM_W-1:0] steps);
		div_t r;
		logic [5:0] diff;
		logic [18:0] mag;
		r.neg = last < first;
		diff = r.neg ? first - last : last - first;
		mag = 19'(point) * 19'(diff);
		r.rem = {1'b0, mag, 1'b0} + 21'(steps);
		r.den = {steps, 1'b0};
		r.quo = '0;
		r.first = first;
		return r;
	endfunction

	function automatic div_t div_step(div_t a, int unsigned k);
		div_t r;
		logic [20:0] trial;
		r = a;
		trial = 21'(a.den) << k;
		if (a.rem >= trial) begin
			r.rem = a.rem - trial;
			r.quo[k] = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [5:0] mix_end(div_t a);
		return a.neg ? a.first - a.quo : a.first + a.quo;
	endfunction

endpackage

// ===== hw/rtl/bilinear_rgb565_gradient_pixel_top.sv =====
// Bilinear RGB565 gradient: a pixel (pixel_column, pixel_row) is taken whenever start is
// high, busy never rises, so one pixel per clock is accepted without gaps. Its colour
// appears on pixel_colour with pixel_valid high for one cycle at the end of the pipeline;
// the ten stages are the vertical setup, three stages of the vertical divider (two
// quotient bits each), the edge colour stage, the horizontal setup, three horizontal
// divider stages and the output register. The receiver cannot stall the block, so a
// result must be taken in the cycle it is shown. Corner colours and frame size are written
// through cfg_we/cfg_index/cfg_data and must only change while no pixel is in flight.
`include "bilinear_rgb565_gradient_pixel_top_defines.svh"

module bilinear_rgb565_gradient_pixel_top #(
	parameter int unsigned MAX_DIMENSION = bgp_pkg::MAX_DIMENSION_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [bgp_pkg::COORD_W-1:0]       pixel_column,
	input  logic [bgp_pkg::COORD_W-1:0]       pixel_row,
	output logic                              pixel_valid,
	output logic [bgp_pkg::COLOUR_W-1:0]      pixel_colour,
	input  logic                              cfg_we,
	input  logic [bgp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bgp_pkg::COLOUR_W-1:0]      cfg_data
);

	localparam int unsigned DW = bgp_pkg::DIM_W;
	localparam int unsigned LATENCY = 10;
	localparam logic [16:0] MAX_DIM = 17'(MAX_DIMENSION);

	logic [bgp_pkg::COLOUR_W-1:0] tl_q, tr_q, br_q, bl_q;
	logic [DW-1:0] width_q, height_q;

	logic [16:0] w_dim, h_dim;
	logic [DW-1:0] w_steps, h_steps;
	logic w_deg, h_deg;
	logic [DW-1:0] x_in, y_in;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9;

	bgp_pkg::div_t vdiv_s1 [6];
	bgp_pkg::div_t vdiv_s2 [6];
	bgp_pkg::div_t vdiv_s3 [6];
	bgp_pkg::div_t vdiv_s4 [6];
	bgp_pkg::div_t hdiv_s6 [3];
	bgp_pkg::div_t hdiv_s7 [3];
	bgp_pkg::div_t hdiv_s8 [3];
	bgp_pkg::div_t hdiv_s9 [3];
	logic [DW-1:0] x_s1, x_s2, x_s3, x_s4, x_s5;
	logic [bgp_pkg::COLOUR_W-1:0] left_s5, right_s5;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q <= '0;
			tr_q <= '0;
			br_q <= '0;
			bl_q <= '0;
			width_q <= '0;
			height_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bgp_pkg::REG_TOP_LEFT:     tl_q <= cfg_data;
				bgp_pkg::REG_TOP_RIGHT:    tr_q <= cfg_data;
				bgp_pkg::REG_BOTTOM_RIGHT: br_q <= cfg_data;
				bgp_pkg::REG_BOTTOM_LEFT:  bl_q <= cfg_data;
				bgp_pkg::REG_FRAME_WIDTH:  width_q <= cfg_data[DW-1:0];
				bgp_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data[DW-1:0];
				default: begin
				end
			endcase
		end
	end

	// saturate frame size, then steps and degenerate flags, and clamp the pixel coordinates
	always_comb begin
		w_dim = (17'(width_q) > MAX_DIM) ? MAX_DIM : 17'(width_q);
		h_dim = (17'(height_q) > MAX_DIM) ? MAX_DIM : 17'(height_q);
		w_steps = DW'(w_dim - 17'd1);
		h_steps = DW'(h_dim - 17'd1);
		w_deg = w_dim <= 17'd1;
		h_deg = h_dim <= 17'd1;
		x_in = (DW'(pixel_column) > w_steps) ? w_steps : DW'(pixel_column);
		y_in = (DW'(pixel_row) > h_steps) ? h_steps : DW'(pixel_row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
			pixel_valid <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
			pixel_valid <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		// vertical: channels 0..2 left edge, 3..5 right edge
		for (int unsigned c = 0; c < 3; c++) begin
			vdiv_s1[c] <= bgp_pkg::mix_setup(bgp_pkg::get_ch(tl_q, c),
				bgp_pkg::get_ch(bl_q, c), y_in, h_steps);
			vdiv_s1[c+3] <= bgp_pkg::mix_setup(bgp_pkg::get_ch(tr_q, c),
				bgp_pkg::get_ch(br_q, c), y_in, h_steps);
		end
		x_s1 <= x_in;
		for (int unsigned i = 0; i < 6; i++) begin
			vdiv_s2[i] <= bgp_pkg::div_step(bgp_pkg::div_step(vdiv_s1[i], 5), 4);
			vdiv_s3[i] <= bgp_pkg::div_step(bgp_pkg::div_step(vdiv_s2[i], 3), 2);
			vdiv_s4[i] <= bgp_pkg::div_step(bgp_pkg::div_step(vdiv_s3[i], 1), 0);
		end
		x_s2 <= x_s1;
		x_s3 <= x_s2;
		x_s4 <= x_s3;

		// edge colours
		if (h_deg) begin
			left_s5 <= '0;
			right_s5 <= '0;
		end else begin
			left_s5 <= bgp_pkg::pack565(bgp_pkg::mix_end(vdiv_s4[0]),
				bgp_pkg::mix_end(vdiv_s4[1]), bgp_pkg::mix_end(vdiv_s4[2]));
			right_s5 <= bgp_pkg::pack565(bgp_pkg::mix_end(vdiv_s4[3]),
				bgp_pkg::mix_end(vdiv_s4[4]), bgp_pkg::mix_end(vdiv_s4[5]));
		end
		x_s5 <= x_s4;

		// horizontal
		for (int unsigned c = 0; c < 3; c++) begin
			hdiv_s6[c] <= bgp_pkg::mix_setup(bgp_pkg::get_ch(left_s5, c),
				bgp_pkg::get_ch(right_s5, c), x_s5, w_steps);
			hdiv_s7[c] <= bgp_pkg::div_step(bgp_pkg::div_step(hdiv_s6[c], 5), 4);
			hdiv_s8[c] <= bgp_pkg::div_step(bgp_pkg::div_step(hdiv_s7[c], 3), 2);
			hdiv_s9[c] <= bgp_pkg::div_step(bgp_pkg::div_step(hdiv_s8[c], 1), 0);
		end

		if (w_deg) begin
			pixel_colour <= '0;
		end else begin
			pixel_colour <= bgp_pkg::pack565(bgp_pkg::mix_end(hdiv_s9[0]),
				bgp_pkg::mix_end(hdiv_s9[1]), bgp_pkg::mix_end(hdiv_s9[2]));
		end
	end

	`BGP_ASSERT(a_fixed_latency, clk, arst_n, start && !busy, ##LATENCY pixel_valid)
	`BGP_ASSERT_REM(a_vert_rem, clk, arst_n, valid_s4, vdiv_s4[1])
	`BGP_ASSERT_REM(a_horz_rem, clk, arst_n, valid_s9, hdiv_s9[1])

endmodule
